// ===== sv/length_prefixed_packet_deframer_defines.svh =====
// assertion macros shared by the deframer checker
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH

// property checked only outside reset
`define LPD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lpd check failed");

// property checked on every edge, reset included
`define LPD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("lpd check failed");

`endif

// ===== sv/lpd_pkg.sv =====
package lpd_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int WORD_BYTES = 4;
   localparam int TOP_SHIFT  = 24;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_TYPE     = 3'd1,
      PH_LENGTH   = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_TRAILER  = 3'd4,
      PH_COMPLETE = 3'd5
   } phase_type;

   typedef struct packed {
      logic                cmd;
      logic [BYTE_W-1:0]   rx_byte;
   } req_type;

   typedef struct packed {
      phase_type           phase;
      logic                payload_valid;
      logic [BYTE_W-1:0]   payload_byte;
      logic                payload_last;
      logic                packet_complete;
      logic [WORD_W-1:0]   packet_type;
      logic [WORD_W-1:0]   payload_length;
      logic [WORD_W-1:0]   trailer_word;
   } rsp_type;

endpackage

// ===== sv/lpd_core.sv =====
module lpd_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  lpd_pkg::req_type req,
   output lpd_pkg::rsp_type rsp
);
   import lpd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [WORD_W-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0]   type_ff, type_in;
   logic [WORD_W-1:0]   length_ff, length_in;
   logic [WORD_W-1:0]   trailer_ff, trailer_in;
   logic [WORD_W:0]     cnt_inc;
   logic                word_done;
   logic                body_done;
   logic                pvalid, plast;

   function automatic logic [WORD_W-1:0] shift_in(input logic [WORD_W-1:0] word,
                                                 input logic [BYTE_W-1:0] b);
      shift_in = {b, word[WORD_W-1:BYTE_W]};
   endfunction

   assign cnt_inc   = {1'b0, cnt_ff} + {{WORD_W{1'b0}}, 1'b1};
   assign word_done = cnt_inc >= (WORD_W+1)'(WORD_BYTES);
   assign body_done = cnt_inc >= {1'b0, length_ff};

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      trailer_in = trailer_ff;
      pvalid     = 1'b0;
      plast      = 1'b0;
      if (req.cmd) begin
         phase_in = PH_IDLE;
         cnt_in   = '0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               length_in  = '0;
               trailer_in = '0;
               type_in    = {req.rx_byte, {TOP_SHIFT{1'b0}}};
               cnt_in     = WORD_W'(1);
               phase_in   = PH_TYPE;
            end
            PH_TYPE: begin
               type_in = shift_in(type_ff, req.rx_byte);
               cnt_in  = cnt_inc[WORD_W-1:0];
               if (word_done) begin
                  cnt_in   = '0;
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               length_in = shift_in(length_ff, req.rx_byte);
               cnt_in    = cnt_inc[WORD_W-1:0];
               if (word_done) begin
                  cnt_in   = '0;
                  // empty body skips straight to the trailer
                  phase_in = (length_in == '0) ? PH_TRAILER : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               pvalid = 1'b1;
               cnt_in = cnt_inc[WORD_W-1:0];
               if (body_done) begin
                  plast    = 1'b1;
                  cnt_in   = '0;
                  phase_in = PH_TRAILER;
               end
            end
            PH_TRAILER: begin
               trailer_in = shift_in(trailer_ff, req.rx_byte);
               cnt_in     = cnt_inc[WORD_W-1:0];
               if (word_done) begin
                  cnt_in   = '0;
                  phase_in = PH_COMPLETE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cnt_ff     <= '0;
         type_ff    <= '0;
         length_ff  <= '0;
         trailer_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         type_ff    <= type_in;
         length_ff  <= length_in;
         trailer_ff <= trailer_in;
      end
   end

   always_comb begin
      rsp.phase           = phase_in;
      rsp.payload_valid   = pvalid;
      rsp.payload_byte    = pvalid ? req.rx_byte : '0;
      rsp.payload_last    = plast;
      rsp.packet_complete = (phase_in == PH_COMPLETE);
      rsp.packet_type     = type_in;
      rsp.payload_length  = length_in;
      rsp.trailer_word    = trailer_in;
   end

endmodule

// ===== sv/lpd_outbuf.sv =====
module lpd_outbuf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lpd_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output lpd_pkg::rsp_type out_data
);
   import lpd_pkg::*;

   logic    main_valid_ff;
   rsp_type main_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    fire;
   logic    drain;

   assign in_ready  = !skid_valid_ff;
   assign fire      = in_valid && in_ready;
   assign drain     = out_ready || !main_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (drain) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= fire;
         end
      end else if (fire) begin
         // main register stalled, park the request result in the skid slot
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (drain) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!drain && fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

// ===== sv/length_prefixed_packet_deframer.sv =====
// Length-prefixed packet deframer.
// Request channel (req_valid/req_ready): one request per ready cycle, either a
// received byte (req_cmd = 0, req_rx_byte) or a restart to idle (req_cmd = 1).
// A frame is a 4-byte type, a 4-byte length, that many body bytes and a
// 4-byte trailer, all words little-endian. A zero length skips the body.
// Result channel (rsp_valid/rsp_ready): exactly one result per request, in
// order, carrying the phase after the request, the body byte with its
// valid and last marks, the complete flag and the assembled words.
// Bytes after the trailer are ignored until a restart request.
// Results are registered in the output stage; throughput is one request per
// cycle while req_ready is high, set by the state update of the framing
// state register.
// A two-entry output stage (result register plus skid slot) lets one more
// request in while a result waits; req_ready drops only when both are full
// and recovers the cycle after rsp_ready returns.
// Synchronous reset returns to idle with all words cleared and no result
// pending.
module length_prefixed_packet_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [lpd_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_phase,
   output logic                        rsp_payload_valid,
   output logic [lpd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                        rsp_payload_last,
   output logic                        rsp_packet_complete,
   output logic [lpd_pkg::WORD_W-1:0]  rsp_packet_type,
   output logic [lpd_pkg::WORD_W-1:0]  rsp_payload_length,
   output logic [lpd_pkg::WORD_W-1:0]  rsp_trailer_word
);
   import lpd_pkg::*;

   req_type req;
   rsp_type core_rsp;
   rsp_type out_rsp;
   logic    fire;

   assign req.cmd     = req_cmd;
   assign req.rx_byte = req_rx_byte;
   assign fire        = req_valid && req_ready;

   lpd_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req),
      .rsp   (core_rsp)
   );

   lpd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_rsp)
   );

   assign rsp_phase           = out_rsp.phase;
   assign rsp_payload_valid   = out_rsp.payload_valid;
   assign rsp_payload_byte    = out_rsp.payload_byte;
   assign rsp_payload_last    = out_rsp.payload_last;
   assign rsp_packet_complete = out_rsp.packet_complete;
   assign rsp_packet_type     = out_rsp.packet_type;
   assign rsp_payload_length  = out_rsp.payload_length;
   assign rsp_trailer_word    = out_rsp.trailer_word;

endmodule

// ===== sv/lpd_checker.sv =====
`include "length_prefixed_packet_deframer_defines.svh"

module lpd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [2:0]                  rsp_phase,
   input logic                        rsp_payload_valid,
   input logic                        rsp_payload_last,
   input logic                        rsp_packet_complete,
   input logic [lpd_pkg::WORD_W-1:0]  rsp_packet_type
);
   import lpd_pkg::*;

   // no result pending right after reset
   `LPD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // last mark only rides on a body byte, which leaves the block in the trailer
   `LPD_ASSERT(a_last_on_body, clock, reset,
      rsp_valid && rsp_payload_last |-> rsp_payload_valid &&
      rsp_phase == PH_TRAILER)

   // complete flag tracks the phase code
   `LPD_ASSERT(a_complete_phase, clock, reset,
      rsp_valid |-> rsp_packet_complete == (rsp_phase == PH_COMPLETE))

   // a stalled result holds
   `LPD_ASSERT(a_stall_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase) &&
      $stable(rsp_packet_type))

endmodule

bind length_prefixed_packet_deframer lpd_checker u_lpd_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_phase           (rsp_phase),
   .rsp_payload_valid   (rsp_payload_valid),
   .rsp_payload_last    (rsp_payload_last),
   .rsp_packet_complete (rsp_packet_complete),
   .rsp_packet_type     (rsp_packet_type)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import lpd_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_REQS     = 1700;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 20;
   localparam int MAX_PRINTS      = 40;
   localparam int IDLE_PCT        = 38;
   localparam int MAX_SHORT_LEN   = 64;

   localparam bit CMD_BYTE    = 1'b0;
   localparam bit CMD_RESTART = 1'b1;

   typedef struct {
      bit                cmd;
      logic [BYTE_W-1:0] data;
      bit                lit;
      rsp_type           want;
   } row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_cmd;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [2:0]          rsp_phase;
   logic                rsp_payload_valid;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic                rsp_payload_last;
   logic                rsp_packet_complete;
   logic [WORD_W-1:0]   rsp_packet_type;
   logic [WORD_W-1:0]   rsp_payload_length;
   logic [WORD_W-1:0]   rsp_trailer_word;

   // predicted deframer state
   phase_type           pred_phase;
   logic [WORD_W-1:0]   pred_count;
   logic [WORD_W-1:0]   pred_type;
   logic [WORD_W-1:0]   pred_len;
   logic [WORD_W-1:0]   pred_trailer;

   rsp_type             expected_rsps[$];
   row_type             directed_rows[$];

   int                  errors;
   int                  cycles;
   int                  random_reqs;
   int                  frames_sent;
   int                  frames_done;
   int                  frames_cut;
   int                  body_bytes;
   int                  hold_left;
   bit                  calm;
   bit                  stall_req;

   length_prefixed_packet_deframer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_phase           (rsp_phase),
      .rsp_payload_valid   (rsp_payload_valid),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_last    (rsp_payload_last),
      .rsp_packet_complete (rsp_packet_complete),
      .rsp_packet_type     (rsp_packet_type),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_trailer_word    (rsp_trailer_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] shift_byte(logic [WORD_W-1:0] w,
                                                    logic [BYTE_W-1:0] d);
      return (w >> BYTE_W) | (WORD_W'(d) << TOP_SHIFT);
   endfunction

   // advances the predicted state by one request and returns its result
   function automatic rsp_type deframe_step(bit c, logic [BYTE_W-1:0] d);
      rsp_type r;
      r = '0;
      if (c == CMD_RESTART) begin
         pred_phase = PH_IDLE;
         pred_count = '0;
      end else begin
         case (pred_phase)
            PH_IDLE: begin
               pred_len     = '0;
               pred_trailer = '0;
               pred_type    = WORD_W'(d) << TOP_SHIFT;
               pred_count   = 1;
               pred_phase   = PH_TYPE;
            end
            PH_TYPE: begin
               pred_type  = shift_byte(pred_type, d);
               pred_count = pred_count + 1;
               if (pred_count >= WORD_BYTES) begin
                  pred_count = '0;
                  pred_phase = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               pred_len   = shift_byte(pred_len, d);
               pred_count = pred_count + 1;
               if (pred_count >= WORD_BYTES) begin
                  pred_count = '0;
                  pred_phase = (pred_len == 0) ? PH_TRAILER : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = d;
               pred_count      = pred_count + 1;
               if (pred_count >= pred_len) begin
                  r.payload_last = 1'b1;
                  pred_count     = '0;
                  pred_phase     = PH_TRAILER;
               end
            end
            PH_TRAILER: begin
               pred_trailer = shift_byte(pred_trailer, d);
               pred_count   = pred_count + 1;
               if (pred_count >= WORD_BYTES) begin
                  pred_count = '0;
                  pred_phase = PH_COMPLETE;
               end
            end
            default: ;
         endcase
      end
      r.phase           = pred_phase;
      r.packet_complete = (pred_phase == PH_COMPLETE);
      r.packet_type     = pred_type;
      r.payload_length  = pred_len;
      r.trailer_word    = pred_trailer;
      return r;
   endfunction

   // result with no body byte, for the hand-written rows
   function automatic rsp_type word_view(phase_type p, logic [WORD_W-1:0] t,
                                         logic [WORD_W-1:0] l, logic [WORD_W-1:0] tr);
      rsp_type r;
      r                 = '0;
      r.phase           = p;
      r.packet_complete = (p == PH_COMPLETE);
      r.packet_type     = t;
      r.payload_length  = l;
      r.trailer_word    = tr;
      return r;
   endfunction

   function automatic void add_row(bit c, logic [BYTE_W-1:0] d, bit lit, rsp_type want);
      row_type row;
      row.cmd  = c;
      row.data = d;
      row.lit  = lit;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(string msg);
      if (errors < MAX_PRINTS)
         $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   task automatic compare_field(string name, logic [WORD_W-1:0] got,
                                logic [WORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic check_rsp();
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch("result with no request pending");
         return;
      end
      want = expected_rsps.pop_front();
      compare_field("phase", WORD_W'(rsp_phase), WORD_W'(want.phase));
      compare_field("payload_valid", WORD_W'(rsp_payload_valid),
                    WORD_W'(want.payload_valid));
      compare_field("payload_byte", WORD_W'(rsp_payload_byte),
                    WORD_W'(want.payload_byte));
      compare_field("payload_last", WORD_W'(rsp_payload_last),
                    WORD_W'(want.payload_last));
      compare_field("packet_complete", WORD_W'(rsp_packet_complete),
                    WORD_W'(want.packet_complete));
      compare_field("packet_type", rsp_packet_type, want.packet_type);
      compare_field("payload_length", rsp_payload_length, want.payload_length);
      compare_field("trailer_word", rsp_trailer_word, want.trailer_word);
      if (want.payload_valid)
         body_bytes++;
   endtask

   // offers one request, waits for it to be taken, then maybe idles a while
   task automatic send_req(bit c, logic [BYTE_W-1:0] d, bit use_lit, rsp_type lit);
      rsp_type predicted;
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_rx_byte <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = deframe_step(c, d);
      expected_rsps.push_back(use_lit ? lit : predicted);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < IDLE_PCT);
      end
   endtask

   // one frame with random content, sometimes cut short, then one or two restarts
   task automatic send_frame();
      logic [WORD_W-1:0] type_w;
      logic [WORD_W-1:0] len_w;
      logic [BYTE_W-1:0] frame_bytes[$];
      int                body_n;
      int                cut;
      int                r;
      type_w = $urandom;
      r      = $urandom_range(99);
      if (r < 15)
         len_w = '0;
      else if (r < 80)
         len_w = $urandom_range(8, 1);
      else if (r < 93)
         len_w = $urandom_range(MAX_SHORT_LEN, 9);
      else
         len_w = $urandom | 32'h0001_0000;   // too long to finish, restart inside body
      for (int i = 0; i < WORD_BYTES; i++)
         frame_bytes.push_back(type_w[BYTE_W*i +: BYTE_W]);
      for (int i = 0; i < WORD_BYTES; i++)
         frame_bytes.push_back(len_w[BYTE_W*i +: BYTE_W]);
      body_n = (len_w > MAX_SHORT_LEN) ? $urandom_range(12, 1) : int'(len_w);
      for (int i = 0; i < body_n; i++)
         frame_bytes.push_back(BYTE_W'($urandom_range(255)));
      if (len_w <= MAX_SHORT_LEN)
         for (int i = 0; i < WORD_BYTES; i++)
            frame_bytes.push_back(BYTE_W'($urandom_range(255)));
      cut = frame_bytes.size();
      if (len_w <= MAX_SHORT_LEN && $urandom_range(99) < 12)
         cut = $urandom_range(frame_bytes.size() - 1, 1);
      frames_sent++;
      for (int i = 0; i < cut; i++) begin
         send_req(CMD_BYTE, frame_bytes[i], 1'b0, '0);
         random_reqs++;
      end
      if (len_w <= MAX_SHORT_LEN && cut == frame_bytes.size()) begin
         frames_done++;
         // stray bytes after the trailer
         repeat ($urandom_range(3)) begin
            send_req(CMD_BYTE, BYTE_W'($urandom_range(255)), 1'b0, '0);
            random_reqs++;
         end
      end else begin
         frames_cut++;
      end
      send_req(CMD_RESTART, BYTE_W'($urandom_range(255)), 1'b0, '0);
      random_reqs++;
      if ($urandom_range(99) < 5) begin
         send_req(CMD_RESTART, BYTE_W'($urandom_range(255)), 1'b0, '0);
         random_reqs++;
      end
   endtask

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_rsp();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_req) begin
            stall_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("run stopped after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int frame_no;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = CMD_BYTE;
      req_rx_byte  = '0;
      calm         = 1'b0;
      stall_req    = 1'b0;
      errors       = 0;
      random_reqs  = 0;
      frames_sent  = 0;
      frames_done  = 0;
      frames_cut   = 0;
      body_bytes   = 0;
      frame_no     = 0;
      pred_phase   = PH_IDLE;
      pred_count   = '0;
      pred_type    = '0;
      pred_len     = '0;
      pred_trailer = '0;

      // restart straight out of reset
      add_row(CMD_RESTART, 8'hFF, 1'b1, word_view(PH_IDLE, 32'h0, 32'h0, 32'h0));
      // zero-length frame goes straight to the trailer
      add_row(CMD_BYTE, 8'hFF, 1'b1, word_view(PH_TYPE, 32'hFF00_0000, 32'h0, 32'h0));
      add_row(CMD_BYTE, 8'h00, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'h00, 1'b1, word_view(PH_LENGTH, 32'h00FF_00FF, 32'h0, 32'h0));
      add_row(CMD_BYTE, 8'h00, 1'b0, '0);
      add_row(CMD_BYTE, 8'h00, 1'b0, '0);
      add_row(CMD_BYTE, 8'h00, 1'b0, '0);
      add_row(CMD_BYTE, 8'h00, 1'b1, word_view(PH_TRAILER, 32'h00FF_00FF, 32'h0, 32'h0));
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b1,
              word_view(PH_COMPLETE, 32'h00FF_00FF, 32'h0, 32'hFFFF_FFFF));
      // byte after completion is dropped
      add_row(CMD_BYTE, 8'h5A, 1'b1,
              word_view(PH_COMPLETE, 32'h00FF_00FF, 32'h0, 32'hFFFF_FFFF));
      // restart keeps the words visible
      add_row(CMD_RESTART, 8'hA5, 1'b1,
              word_view(PH_IDLE, 32'h00FF_00FF, 32'h0, 32'hFFFF_FFFF));
      // first byte clears the old words; max length, restart inside the body
      add_row(CMD_BYTE, 8'h12, 1'b1, word_view(PH_TYPE, 32'h1200_0000, 32'h0, 32'h0));
      add_row(CMD_BYTE, 8'h34, 1'b0, '0);
      add_row(CMD_BYTE, 8'h56, 1'b0, '0);
      add_row(CMD_BYTE, 8'h78, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b0, '0);
      add_row(CMD_BYTE, 8'hFF, 1'b1,
              word_view(PH_PAYLOAD, 32'h7856_3412, 32'hFFFF_FFFF, 32'h0));
      add_row(CMD_BYTE, 8'h00, 1'b0, '0);
      add_row(CMD_RESTART, 8'h00, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_req(directed_rows[i].cmd, directed_rows[i].data,
                  directed_rows[i].lit, directed_rows[i].want);

      while (random_reqs < RANDOM_REQS) begin
         frame_no++;
         calm = (frame_no >= 40 && frame_no < 55);
         if (frame_no == 10 || frame_no == 60)
            stall_req = 1'b1;
         // sender pause until every result is back
         if (frame_no == 25 || frame_no == 70) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_rsps.size() != 0);
         end
         send_frame();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("results still outstanding at end of run");

      $display("%0d directed and %0d random requests over %0d frames", directed_rows.size(),
               random_reqs, frames_sent);
      $display("%0d frames completed, %0d cut short, %0d body bytes checked, %0d errors",
               frames_done, frames_cut, body_bytes, errors);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
